// ===== hw/rtl/sha_pkg.sv =====
`timescale 1ns / 1ps

package sha_pkg;

   // Word and field widths
   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int OPCODE_W  = 1;
   localparam int INDEX_W   = 3;
   localparam int CHAIN_N   = 8;
   localparam int BLOCK_W   = 512;
   localparam int FILL_W    = 6;
   localparam int ROUND_W   = 6;
   localparam int LENGTH_W  = 64;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_ABSORB = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_FINISH = 1'b1;

   // Padding constants
   localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
   localparam logic [BYTE_W-1:0] PAD_ZERO  = 8'h00;
   localparam logic [FILL_W-1:0] LEN_START = 6'd56;
   localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
   localparam logic [INDEX_W-1:0] WORD_LAST  = 3'd7;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   localparam logic [WORD_W-1:0] H_INIT [0:CHAIN_N-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Rotate right by a constant amount
   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
      logic [2*WORD_W-1:0] d;
      d = {x, x} >> n;
      return d[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [WORD_W-1:0] choose(input logic [WORD_W-1:0] e,
                                                input logic [WORD_W-1:0] f,
                                                input logic [WORD_W-1:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [WORD_W-1:0] majority(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// ===== hw/rtl/sha_if.sv =====
`timescale 1ns / 1ps

// Request channel: one opcode and message byte per word
interface sha_req_if;
   import sha_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// Response channel: one digest word per word
interface sha_rsp_if;
   import sha_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  digest_word;
   logic [INDEX_W-1:0] word_index;
   logic               last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

// ===== hw/rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each absorb word on req_ch shifts one byte into the block;
// the byte that completes a 64-byte block also starts the compression, which
// holds req_ch.ready low through the load, 64 rounds through the one shared
// round unit at one round per cycle, and the chain update. A finish word pads
// the tail one byte per cycle, runs one compression when fewer than 56 bytes
// are pending (else two), and then presents the eight digest words on rsp_ch,
// most significant first, one per cycle that rsp_ch.ready allows; req_ch.ready
// stays low until the last one is taken, after which the block is set up for
// the next message.
module sha256_stream_hasher (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req_ch,
   sha_rsp_if.source rsp_ch
);
   import sha_pkg::*;

   state_type state_ff, state_in;

   logic [BLOCK_W-1:0]               block_ff, block_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [LENGTH_W-1:0]              bits_ff, bits_in;
   logic [CHAIN_N-1:0][WORD_W-1:0]   vars_ff, vars_in;
   logic [CHAIN_N-1:0][WORD_W-1:0]   chain_ff, chain_in;
   logic [ROUND_W-1:0]               round_ff, round_in;
   logic                             pad_active_ff, pad_active_in;
   logic                             pad_first_ff, pad_first_in;
   logic                             pad_done_ff, pad_done_in;
   logic                             in_len_ff, in_len_in;
   logic [INDEX_W-1:0]               len_cnt_ff, len_cnt_in;
   logic [INDEX_W-1:0]               emit_cnt_ff, emit_cnt_in;

   logic                req_fire;
   logic                rsp_fire;
   logic                push_en;
   logic [BYTE_W-1:0]   push_byte;
   logic                len_phase;
   logic [FILL_W-1:0]   len_shift;
   logic [BYTE_W-1:0]   len_byte;
   logic [BYTE_W-1:0]   pad_byte;
   logic [WORD_W-1:0]   w_cur;
   logic [WORD_W-1:0]   w_next;
   logic [WORD_W-1:0]   t1;
   logic [WORD_W-1:0]   t2;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Pick the padding byte: marker, zeros, then the big-endian bit length
   assign len_phase = in_len_ff || (!pad_first_ff && (fill_ff == LEN_START));
   assign len_shift = {~len_cnt_ff, 3'b000};
   assign len_byte  = bits_ff[len_shift +: BYTE_W];
   assign pad_byte  = pad_first_ff ? PAD_MARK : (len_phase ? len_byte : PAD_ZERO);

   // Round unit and message schedule, oldest schedule word at the top
   assign w_cur  = block_ff[BLOCK_W-1 -: WORD_W];
   assign w_next = small_sigma1(block_ff[1*WORD_W +: WORD_W])
                 + block_ff[6*WORD_W +: WORD_W]
                 + small_sigma0(block_ff[14*WORD_W +: WORD_W])
                 + w_cur;
   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + choose(vars_ff[4], vars_ff[5], vars_ff[6])
             + ROUND_K[round_ff] + w_cur;
   assign t2 = big_sigma0(vars_ff[0]) + majority(vars_ff[0], vars_ff[1], vars_ff[2]);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.opcode == OP_FINISH) begin
                  state_in = ST_PAD;
               end else if (fill_ff == FILL_LAST) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == FILL_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (pad_done_ff) begin
               state_in = ST_EMIT;
            end else if (pad_active_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && (emit_cnt_ff == WORD_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshakes, result word and byte push control
   always_comb begin
      req_ch.ready       = (state_ff == ST_IDLE);
      rsp_ch.valid       = (state_ff == ST_EMIT);
      rsp_ch.digest_word = chain_ff[0];
      rsp_ch.word_index  = emit_cnt_ff;
      rsp_ch.last_word   = (emit_cnt_ff == WORD_LAST);
      push_en            = 1'b0;
      push_byte          = req_ch.data_byte;
      case (state_ff)
         ST_IDLE: push_en = req_fire && (req_ch.opcode == OP_ABSORB);
         ST_PAD: begin
            push_en   = 1'b1;
            push_byte = pad_byte;
         end
         default: push_en = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      block_in      = block_ff;
      fill_in       = fill_ff;
      bits_in       = bits_ff;
      vars_in       = vars_ff;
      chain_in      = chain_ff;
      round_in      = round_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      pad_done_in   = pad_done_ff;
      in_len_in     = in_len_ff;
      len_cnt_in    = len_cnt_ff;
      emit_cnt_in   = emit_cnt_ff;

      // Shift one byte into the block; the fill wraps to zero on the last one
      if (push_en) begin
         block_in = {block_ff[BLOCK_W-BYTE_W-1:0], push_byte};
         fill_in  = fill_ff + 6'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.opcode == OP_ABSORB) begin
                  bits_in = bits_ff + 64'd8;
               end else begin
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
               end
            end
         end
         ST_PAD: begin
            pad_first_in = 1'b0;
            if (len_phase) begin
               in_len_in  = 1'b1;
               len_cnt_in = len_cnt_ff + 3'd1;
               if (len_cnt_ff == WORD_LAST) begin
                  pad_done_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            vars_in  = chain_ff;
            round_in = '0;
         end
         ST_ROUND: begin
            vars_in  = {vars_ff[6], vars_ff[5], vars_ff[4], vars_ff[3] + t1,
                        vars_ff[2], vars_ff[1], vars_ff[0], t1 + t2};
            block_in = {block_ff[BLOCK_W-WORD_W-1:0], w_next};
            round_in = round_ff + 6'd1;
         end
         ST_UPDATE: begin
            for (int j = 0; j < CHAIN_N; j++) begin
               chain_in[j] = chain_ff[j] + vars_ff[j];
            end
         end
         ST_EMIT: begin
            // Advance the digest and refill the chain with the initial values
            if (rsp_fire) begin
               for (int j = 0; j < CHAIN_N - 1; j++) begin
                  chain_in[j] = chain_ff[j+1];
               end
               chain_in[CHAIN_N-1] = H_INIT[emit_cnt_ff];
               emit_cnt_in         = emit_cnt_ff + 3'd1;
               if (emit_cnt_ff == WORD_LAST) begin
                  bits_in       = '0;
                  pad_active_in = 1'b0;
                  pad_done_in   = 1'b0;
                  in_len_in     = 1'b0;
               end
            end
         end
         default: begin
            round_in = round_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         bits_ff       <= '0;
         round_ff      <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         pad_done_ff   <= 1'b0;
         in_len_ff     <= 1'b0;
         len_cnt_ff    <= '0;
         emit_cnt_ff   <= '0;
         for (int j = 0; j < CHAIN_N; j++) begin
            chain_ff[j] <= H_INIT[j];
         end
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bits_ff       <= bits_in;
         round_ff      <= round_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         pad_done_ff   <= pad_done_in;
         in_len_ff     <= in_len_in;
         len_cnt_ff    <= len_cnt_in;
         emit_cnt_ff   <= emit_cnt_in;
         chain_ff      <= chain_in;
      end
   end

   // Block window and working variables
   always_ff @(posedge clock) begin
      block_ff <= block_in;
      vars_ff  <= vars_in;
   end

   // A request is never taken while a digest word is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !rsp_ch.valid)
      else $error("request taken while digest pending");

   // Padding always ends on a block boundary before the digest goes out
   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((fill_ff == '0) && pad_done_ff))
      else $error("digest emitted with bytes still pending");

   // The last digest word leaves the block ready for a fresh message
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_word) |=>
         ((state_ff == ST_IDLE) && (bits_ff == '0) && (chain_ff[0] == H_INIT[0])))
      else $error("block not reinitialized after digest");

   // The sixty-fourth round hands over to the chain update
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (round_ff == ROUND_LAST)) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after the last round");

endmodule

// ===== verif/sha256_stream_hasher_test.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_test;
   import sha_pkg::*;

   localparam int ITEM_TARGET  = 360;
   localparam int CALM_FROM    = 320;
   localparam int SETTLE_WAIT  = 300;
   localparam int REPORT_LIMIT = 10;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   data_byte;
      logic                known;
      logic [255:0]        digest;
   } directed_row_type;

   typedef struct {
      logic [WORD_W-1:0]  digest_word;
      logic [INDEX_W-1:0] word_index;
      logic               last_word;
   } digest_entry_type;

   // Empty message twice (second with junk data on finish), "abc", then bit extremes
   localparam int DIRECTED_N = 13;
   localparam directed_row_type DIRECTED [DIRECTED_N] = '{
      '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      '{OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
      '{OP_ABSORB, 8'h61, 1'b0, 256'h0},
      '{OP_ABSORB, 8'h62, 1'b0, 256'h0},
      '{OP_ABSORB, 8'h63, 1'b0, 256'h0},
      '{OP_FINISH, 8'ha5, 1'b1, ABC_DIGEST},
      '{OP_ABSORB, 8'h00, 1'b0, 256'h0},
      '{OP_ABSORB, 8'hff, 1'b0, 256'h0},
      '{OP_ABSORB, 8'h55, 1'b0, 256'h0},
      '{OP_ABSORB, 8'haa, 1'b0, 256'h0},
      '{OP_FINISH, 8'h5a, 1'b0, 256'h0},
      '{OP_ABSORB, 8'h80, 1'b0, 256'h0},
      '{OP_FINISH, 8'h7f, 1'b0, 256'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha_req_if req_ch ();
   sha_rsp_if rsp_ch ();

   sha256_stream_hasher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Hash state mirrored from the accepted request words
   logic [31:0]   hash_chain [8];
   logic [7:0]    hash_block [64];
   int unsigned   hash_fill;
   logic [63:0]   hash_bits;

   digest_entry_type digest_q [$];
   int               error_count = 0;
   int               words_sent = 0;
   int               rsp_stall_pct = 0;
   int               rsp_stall_left = 0;
   bit               calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void hash_start();
      for (int i = 0; i < 8; i++) hash_chain[i] = SHA_IV[i];
      hash_fill = 0;
      hash_bits = '0;
   endfunction

   // Run the 64 rounds over the gathered block and fold into the chain
   function automatic void hash_compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
      hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
   endfunction

   function automatic void hash_push(input logic [7:0] b);
      hash_block[hash_fill] = b;
      hash_fill++;
      if (hash_fill == 64) begin
         hash_compress();
         hash_fill = 0;
      end
   endfunction

   // Pad with the marker, zeros and the message bit length; return the digest
   function automatic logic [255:0] hash_close();
      logic [63:0]  len;
      logic [255:0] d;
      len = hash_bits;
      hash_push(PAD_MARK);
      while (hash_fill != 56) hash_push(PAD_ZERO);
      for (int i = 0; i < 8; i++) hash_push(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) d[255-32*i -: 32] = hash_chain[i];
      hash_start();
      return d;
   endfunction

   function automatic void queue_digest(input logic [255:0] d);
      digest_entry_type ent;
      for (int i = 0; i < 8; i++) begin
         ent.digest_word = d[255-32*i -: 32];
         ent.word_index  = INDEX_W'(i);
         ent.last_word   = (INDEX_W'(i) == WORD_LAST);
         digest_q.push_back(ent);
      end
   endfunction

   // Present one word and hold it until accepted, then advance the mirror
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [7:0] b,
                            input logic known, input logic [255:0] typed);
      logic [255:0] d;
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      if (op == OP_ABSORB) begin
         hash_bits += 64'd8;
         hash_push(b);
      end else begin
         d = hash_close();
         queue_digest(known ? typed : d);
      end
   endtask

   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // Hold off the sender until every pending digest word is out
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   // Check each accepted digest word against the oldest expectation
   always @(posedge clock) begin
      digest_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digest_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected digest word: word %h index %0d last %0b",
                        rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
         end else begin
            want = digest_q.pop_front();
            if (rsp_ch.digest_word !== want.digest_word ||
                rsp_ch.word_index !== want.word_index ||
                rsp_ch.last_word !== want.last_word) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                           want.digest_word, want.word_index, want.last_word,
                           rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
            end
         end
      end
   end

   // Stall the result channel in random bursts, none once the run is calm
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left = $urandom_range(1, 9) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("sha256_stream_hasher regression: fail");
      $finish;
   end

   initial begin
      int len;
      int gap_pct;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = OP_ABSORB;
      req_ch.data_byte = '0;
      for (int i = 0; i < 64; i++) hash_block[i] = '0;
      hash_start();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      rsp_stall_pct = 20;
      for (int i = 0; i < DIRECTED_N; i++)
         send_word(DIRECTED[i].opcode, DIRECTED[i].data_byte, DIRECTED[i].known,
                   DIRECTED[i].digest);
      drain_results();

      // Random messages, lengths clustered around the padding boundaries
      while (words_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0: begin gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin gap_pct = 10; rsp_stall_pct = 15; end
            default: begin gap_pct = 35; rsp_stall_pct = 40; end
         endcase
         if (!calm && $urandom_range(0, 4) == 0) drain_results();
         case ($urandom_range(0, 9))
            0:       len = 0;
            1, 2, 3: len = $urandom_range(1, 8);
            4, 5:    len = $urandom_range(9, 40);
            6, 7:    len = $urandom_range(54, 57);
            8:       len = $urandom_range(62, 66);
            default: len = $urandom_range(119, 121);
         endcase
         // Trim the last message so the run ends near the item target
         if (len > ITEM_TARGET - words_sent - 1) len = ITEM_TARGET - words_sent - 1;
         for (int k = 0; k <= len; k++) begin
            if (words_sent >= CALM_FROM) calm = 1'b1;
            if (!calm && $urandom_range(0, 99) < gap_pct) idle_req($urandom_range(1, 9));
            if (k == len)
               send_word(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
            else
               send_word(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
         end
      end

      // Drop valid, wait for the last digest, then let the block settle
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (digest_q.size() != 0) begin
         error_count += digest_q.size();
         $display("%0d digest words never arrived", digest_q.size());
      end
      if (error_count == 0) begin
         $display("sha256_stream_hasher regression: pass");
      end else begin
         $display("sha256_stream_hasher regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_if.sv
hw/rtl/sha256_stream_hasher.sv
verif/sha256_stream_hasher_test.sv
